>>> src/cal_pkg.sv
// Shared types, action codes and calendar helper functions for the calendar clock.
package cal_pkg;

    // Action codes carried in the action field
    localparam logic [1:0] ACT_TICK = 2'd0;
    localparam logic [1:0] ACT_SET  = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;
    localparam logic [1:0] ACT_PAST = 2'd3;

    // Divisors served by the shared divider
    localparam logic [6:0] DIV_CENT = 7'd100;
    localparam logic [6:0] DIV_WEEK = 7'd7;

    // Reciprocals for the shared divider: quotient is (x * R) >> 24 against 100,
    // exact below 2^17, and (x * R) >> 16 against 7, exact below 13107
    localparam logic [17:0] RECIP_CENT = 18'd167773;
    localparam logic [17:0] RECIP_WEEK = 18'd9363;

    // Reset values of the time counters
    localparam logic [7:0]  RST_SEC   = 8'd0;
    localparam logic [7:0]  RST_MIN   = 8'd0;
    localparam logic [7:0]  RST_HOUR  = 8'd8;
    localparam logic [7:0]  RST_DAY   = 8'd11;
    localparam logic [7:0]  RST_MONTH = 8'd9;
    localparam logic [15:0] RST_YEAR  = 16'd2017;
    localparam logic [2:0]  RST_WDAY  = 3'd1;

    // Bias on the weekday sum: a multiple of 7 above twice the largest century,
    // less one for the day term, so the sum never goes negative
    localparam logic [12:0] WD_BIAS = 13'd1322;

    // Input beat
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] set_year;
        logic [7:0]  set_month;
        logic [7:0]  set_day;
        logic [7:0]  set_hour;
        logic [7:0]  set_minute;
        logic [7:0]  set_second;
        logic [15:0] days_back;
    } cal_in_t;

    // Result beat
    typedef struct packed {
        logic [15:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
        logic [2:0]  weekday;
        logic [7:0]  past_month;
        logic [7:0]  past_day;
    } cal_out_t;

    // Request into the shared divider
    typedef struct packed {
        logic        start;
        logic [6:0]  divisor;
        logic [16:0] dividend;
    } cal_div_req_t;

    // Response from the shared divider
    typedef struct packed {
        logic        done;
        logic [16:0] quot;
        logic [6:0]  rem;
    } cal_div_rsp_t;

    // Gregorian leap rule from y / 100 and y % 100 and the low bits of y
    function automatic logic is_leap(logic [1:0] ylo, logic [16:0] q, logic [6:0] r);
        if (r == 7'd0) begin
            return (q[1:0] == 2'b00);
        end
        return (ylo == 2'b00);
    endfunction

    // Days in a month; anything outside the short months counts 31
    function automatic logic [7:0] month_len(logic [7:0] m, logic leap);
        logic [7:0] len;
        case (m)
            8'd2:                         len = leap ? 8'd29 : 8'd28;
            8'd4, 8'd6, 8'd9, 8'd11:      len = 8'd30;
            default:                      len = 8'd31;
        endcase
        return len;
    endfunction

    // (26 * (m + 1)) / 10 by reciprocal multiply, exact for the whole range
    function automatic logic [9:0] month_term(logic [7:0] m);
        logic [12:0] x;
        logic [29:0] p;
        x = 13'({5'd0, m} + 13'd1) * 13'd26;
        p = 30'(x) * 30'd52429;
        return p[28:19];
    endfunction

endpackage

>>> src/cal_cdiv.sv
// Shared divider by 100 or 7 through reciprocal multiplication.
module cal_cdiv (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cal_pkg::cal_div_req_t req,
    output cal_pkg::cal_div_rsp_t rsp
);

    logic        quo_step_reg;
    logic        rem_step_reg;
    logic        done_reg;
    logic [6:0]  div_reg;
    logic [16:0] dd_reg;
    logic [16:0] quo_reg;
    logic [6:0]  rem_reg;

    logic [17:0] recip;
    logic [34:0] prod;
    logic [16:0] quot;
    logic [13:0] back;
    logic [6:0]  rem_lo;

    // Quotient from the reciprocal; the remainder fits seven bits, so low bits suffice
    always_comb begin
        recip  = (div_reg == cal_pkg::DIV_WEEK) ? cal_pkg::RECIP_WEEK : cal_pkg::RECIP_CENT;
        prod   = {18'd0, dd_reg} * {17'd0, recip};
        quot   = (div_reg == cal_pkg::DIV_WEEK) ? prod[32:16] : {6'd0, prod[34:24]};
        back   = quo_reg[6:0] * div_reg;
        rem_lo = dd_reg[6:0] - back[6:0];
    end

    // Load, then quotient, then remainder with done
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quo_step_reg <= 1'b0;
            rem_step_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            quo_step_reg <= req.start;
            rem_step_reg <= quo_step_reg;
            done_reg     <= rem_step_reg;
            if (req.start) begin
                div_reg <= req.divisor;
                dd_reg  <= req.dividend;
            end
            if (quo_step_reg) begin
                quo_reg <= quot;
            end
            if (rem_step_reg) begin
                rem_reg <= rem_lo;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

>>> src/calendar_clock.sv
// Calendar clock: time counters, tick carries, set, read and past-date query.
// Read or plain tick goes straight to the result; set waits on two passes of the shared
// reciprocal divider, and a tick with an hour carry waits on three.
// Past-date query: steps back a month at a time, plus one divider pass per February.
// One item at a time: the next beat can be taken in the same cycle as the result is offered.
// Synchronous active-low reset loads 2017-09-11 08:00:00, Monday; no clearing pass.
module calendar_clock (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cal_pkg::cal_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cal_pkg::cal_out_t m_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK_WAIT,
        ST_WD_START,
        ST_WD_WAIT1,
        ST_WD_WAIT2,
        ST_PAST,
        ST_PAST_WAIT,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic [7:0]  sec_reg, min_reg, hour_reg, day_reg, month_reg;
    logic [15:0] year_reg;
    logic [2:0]  wday_reg;

    logic [1:0]  act_reg;
    logic [7:0]  pm_reg, pd_reg;
    logic [15:0] py_reg, n_reg;
    logic [9:0]  mterm_reg;

    cal_pkg::cal_div_req_t div_req_reg;
    cal_pkg::cal_div_rsp_t div_rsp;
    cal_pkg::cal_out_t     out_reg;
    logic                  m_valid_reg;

    cal_cdiv u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req_reg),
        .rsp     (div_rsp)
    );

    // Tick carry helpers
    logic [7:0] sec_inc, min_inc, hour_inc, day_inc, month_inc;
    logic [7:0] tick_len;
    logic       div_leap;
    logic [1:0] leap_ylo;

    // Weekday helpers
    logic        wd_adj;
    logic [16:0] wd_year;
    logic [7:0]  wd_month;
    logic [9:0]  cent;
    logic [12:0] wd_sum;

    // Past-date helpers
    logic [7:0]  pd_dec, past_step;
    logic [7:0]  pm_dec;
    logic [15:0] py_dec;

    always_comb begin
        sec_inc   = sec_reg + 8'd1;
        min_inc   = min_reg + 8'd1;
        hour_inc  = hour_reg + 8'd1;
        day_inc   = day_reg + 8'd1;
        month_inc = month_reg + 8'd1;

        leap_ylo = (state_reg == ST_PAST_WAIT) ? py_reg[1:0] : year_reg[1:0];
        div_leap = cal_pkg::is_leap(leap_ylo, div_rsp.quot, div_rsp.rem);
        tick_len = cal_pkg::month_len(month_reg, div_leap);

        // January and February count as months 13 and 14 of the year before
        wd_adj   = (month_reg == 8'd1) || (month_reg == 8'd2);
        wd_year  = {1'b0, year_reg} + (wd_adj ? 17'd399 : 17'd400);
        wd_month = wd_adj ? (month_reg + 8'd12) : month_reg;

        // Weekday sum from century, year of century, month term and day, kept non-negative
        cent   = div_rsp.quot[9:0];
        wd_sum = cal_pkg::WD_BIAS + {6'd0, div_rsp.rem} + {8'd0, div_rsp.rem[6:2]}
               + {5'd0, cent[9:2]} + {3'd0, mterm_reg} + {5'd0, day_reg}
               - {2'd0, cent, 1'b0};

        // Past query: skip down to day 1, or by the days left, in one step, then cross a month
        pd_dec    = pd_reg - 8'd1;
        past_step = ({8'd0, pd_dec} < n_reg) ? pd_dec : n_reg[7:0];
        pm_dec    = (pm_reg > 8'd1) ? (pm_reg - 8'd1) : 8'd12;
        py_dec    = (pm_reg > 8'd1) ? py_reg : (py_reg - 16'd1);
    end

    // Sequencer, counters and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            sec_reg           <= cal_pkg::RST_SEC;
            min_reg           <= cal_pkg::RST_MIN;
            hour_reg          <= cal_pkg::RST_HOUR;
            day_reg           <= cal_pkg::RST_DAY;
            month_reg         <= cal_pkg::RST_MONTH;
            year_reg          <= cal_pkg::RST_YEAR;
            wday_reg          <= cal_pkg::RST_WDAY;
            div_req_reg.start <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            div_req_reg.start <= 1'b0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        act_reg <= s_data.action;
                        case (s_data.action)
                            cal_pkg::ACT_TICK: begin
                                if (sec_inc < 8'd60) begin
                                    sec_reg   <= sec_inc;
                                    state_reg <= ST_DONE;
                                end else if (min_inc < 8'd60) begin
                                    sec_reg   <= 8'd0;
                                    min_reg   <= min_inc;
                                    state_reg <= ST_DONE;
                                end else if (hour_inc < 8'd24) begin
                                    sec_reg   <= 8'd0;
                                    min_reg   <= 8'd0;
                                    hour_reg  <= hour_inc;
                                    state_reg <= ST_DONE;
                                end else begin
                                    // Day rollover: need the leap rule for this year
                                    sec_reg              <= 8'd0;
                                    min_reg              <= 8'd0;
                                    hour_reg             <= 8'd0;
                                    day_reg              <= day_inc;
                                    div_req_reg.start    <= 1'b1;
                                    div_req_reg.divisor  <= cal_pkg::DIV_CENT;
                                    div_req_reg.dividend <= {1'b0, year_reg};
                                    state_reg            <= ST_TICK_WAIT;
                                end
                            end
                            cal_pkg::ACT_SET: begin
                                year_reg  <= s_data.set_year;
                                month_reg <= s_data.set_month;
                                day_reg   <= s_data.set_day;
                                hour_reg  <= s_data.set_hour;
                                min_reg   <= s_data.set_minute;
                                sec_reg   <= s_data.set_second;
                                state_reg <= ST_WD_START;
                            end
                            cal_pkg::ACT_PAST: begin
                                pm_reg    <= month_reg;
                                pd_reg    <= day_reg;
                                py_reg    <= year_reg;
                                n_reg     <= s_data.days_back;
                                state_reg <= ST_PAST;
                            end
                            default: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_TICK_WAIT: begin
                    if (div_rsp.done) begin
                        if (day_reg > tick_len) begin
                            day_reg <= 8'd1;
                            if (month_inc > 8'd12) begin
                                month_reg <= 8'd1;
                                year_reg  <= year_reg + 16'd1;
                            end else begin
                                month_reg <= month_inc;
                            end
                        end
                        state_reg <= ST_WD_START;
                    end
                end
                ST_WD_START: begin
                    // Split the adjusted year into century and year of century
                    mterm_reg            <= cal_pkg::month_term(wd_month);
                    div_req_reg.start    <= 1'b1;
                    div_req_reg.divisor  <= cal_pkg::DIV_CENT;
                    div_req_reg.dividend <= wd_year;
                    state_reg            <= ST_WD_WAIT1;
                end
                ST_WD_WAIT1: begin
                    if (div_rsp.done) begin
                        div_req_reg.start    <= 1'b1;
                        div_req_reg.divisor  <= cal_pkg::DIV_WEEK;
                        div_req_reg.dividend <= {4'd0, wd_sum};
                        state_reg            <= ST_WD_WAIT2;
                    end
                end
                ST_WD_WAIT2: begin
                    if (div_rsp.done) begin
                        wday_reg  <= (div_rsp.rem == 7'd0) ? 3'd7 : div_rsp.rem[2:0];
                        state_reg <= ST_DONE;
                    end
                end
                ST_PAST: begin
                    if (n_reg == 16'd0) begin
                        state_reg <= ST_DONE;
                    end else if (pd_reg > 8'd1) begin
                        pd_reg <= pd_reg - past_step;
                        n_reg  <= n_reg - {8'd0, past_step};
                    end else begin
                        pm_reg <= pm_dec;
                        py_reg <= py_dec;
                        n_reg  <= n_reg - 16'd1;
                        if (pm_dec == 8'd2) begin
                            // February: length waits on the leap rule
                            div_req_reg.start    <= 1'b1;
                            div_req_reg.divisor  <= cal_pkg::DIV_CENT;
                            div_req_reg.dividend <= {1'b0, py_dec};
                            state_reg            <= ST_PAST_WAIT;
                        end else begin
                            pd_reg <= cal_pkg::month_len(pm_dec, 1'b0);
                        end
                    end
                end
                ST_PAST_WAIT: begin
                    if (div_rsp.done) begin
                        pd_reg    <= div_leap ? 8'd29 : 8'd28;
                        state_reg <= ST_PAST;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        out_reg.year    <= year_reg;
                        out_reg.month   <= month_reg;
                        out_reg.day     <= day_reg;
                        out_reg.hour    <= hour_reg;
                        out_reg.minute  <= min_reg;
                        out_reg.second  <= sec_reg;
                        out_reg.weekday <= wday_reg;
                        if (act_reg == cal_pkg::ACT_PAST) begin
                            out_reg.past_month <= pm_reg;
                            out_reg.past_day   <= pd_reg;
                        end else begin
                            out_reg.past_month <= 8'd0;
                            out_reg.past_day   <= 8'd0;
                        end
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
